// ----- src/barycentric_interpolator_macros.svh -----
// Assertion macros used by the barycentric interpolator RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BARYCENTRIC_INTERPOLATOR_MACROS_SVH
`define BARYCENTRIC_INTERPOLATOR_MACROS_SVH

// check under reset gating
`define BARY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define BARY_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/bary_pkg.sv -----
// Shared constants and codes for the barycentric interpolator.
// No dependencies.
package bary_pkg;

  localparam int unsigned CoordBitsDef     = 16;
  localparam int unsigned WeightFracBitsDef = 16;
  localparam int unsigned AttrBitsDef      = 24;
  localparam int unsigned AttrFracBits     = 8;
  localparam int unsigned WeightIntBits    = 4;
  localparam int unsigned QueueDepth       = 2;

  typedef enum logic [1:0] {
    OP_WEIGHTS   = 2'd0,
    OP_BLEND     = 2'd1,
    OP_BLEND_INT = 2'd2,
    OP_RSVD      = 2'd3
  } opcode_e;

endpackage

// ----- src/bary_if.sv -----
// Valid/ready channel interfaces for the barycentric interpolator.
// Depends on bary_pkg for default widths.
interface bary_in_if #(
  parameter int unsigned CoordBits = bary_pkg::CoordBitsDef,
  parameter int unsigned AttrBits  = bary_pkg::AttrBitsDef
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic signed [CoordBits-1:0] x1, y1, x2, y2, x3, y3, px, py;
  logic signed [AttrBits-1:0]  attr1, attr2, attr3;

  modport source (output valid, opcode, x1, y1, x2, y2, x3, y3, px, py,
                  attr1, attr2, attr3, input ready);
  modport sink   (input valid, opcode, x1, y1, x2, y2, x3, y3, px, py,
                  attr1, attr2, attr3, output ready);
endinterface

interface bary_out_if #(
  parameter int unsigned WeightBits = bary_pkg::WeightFracBitsDef + bary_pkg::WeightIntBits,
  parameter int unsigned AttrBits   = bary_pkg::AttrBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [WeightBits-1:0] weight1, weight2, weight3;
  logic signed [AttrBits-1:0]   value;
  logic                         degenerate;

  modport source (output valid, weight1, weight2, weight3, value, degenerate,
                  input ready);
  modport sink   (input valid, weight1, weight2, weight3, value, degenerate,
                  output ready);
endinterface

// ----- src/bary_front.sv -----
// Front end: accepts input beats, forms edge differences and products,
// and pushes determinant, numerators and attributes into the queue. Uses bary_pkg.
module bary_front #(
  parameter int unsigned CoordBits = bary_pkg::CoordBitsDef,
  parameter int unsigned AttrBits  = bary_pkg::AttrBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  bary_in_if.sink in_i,
  output logic push_valid_o,
  input  logic push_ready_i,
  output logic [2+3*(2*CoordBits+3)+3*AttrBits-1:0] push_data_o
);
  import bary_pkg::*;

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned MW = 2 * DW;
  localparam int unsigned PW = 2 * CoordBits + 3;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;

  logic [1:0]                 op_q;
  logic signed [AttrBits-1:0] a1_q, a2_q, a3_q;
  logic signed [DW-1:0]       da_q, db_q, dc_q, dd_q, de_q, df_q;
  logic signed [MW-1:0]       pab_q, pcd_q, pae_q, pcf_q, pbf_q, pde_q;
  logic signed [PW-1:0]       det, n1, n2;
  logic                       accept;

  assign in_i.ready   = (state_q == F_IDLE);
  assign accept       = in_i.valid && in_i.ready;
  assign push_valid_o = (state_q == F_PUSH);

  assign det = PW'(pab_q) + PW'(pcd_q);
  assign n1  = PW'(pae_q) + PW'(pcf_q);
  assign n2  = PW'(pbf_q) - PW'(pde_q);
  assign push_data_o = {op_q, det, n1, n2, a1_q, a2_q, a3_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = F_MUL;
      F_MUL:  state_d = F_PUSH;
      F_PUSH: if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_i.opcode;
      a1_q <= in_i.attr1;
      a2_q <= in_i.attr2;
      a3_q <= in_i.attr3;
      da_q <= DW'(in_i.y2) - DW'(in_i.y3);
      db_q <= DW'(in_i.x1) - DW'(in_i.x3);
      dc_q <= DW'(in_i.x3) - DW'(in_i.x2);
      dd_q <= DW'(in_i.y1) - DW'(in_i.y3);
      de_q <= DW'(in_i.px) - DW'(in_i.x3);
      df_q <= DW'(in_i.py) - DW'(in_i.y3);
    end
    if (state_q == F_MUL) begin
      pab_q <= da_q * db_q;
      pcd_q <= dc_q * dd_q;
      pae_q <= da_q * de_q;
      pcf_q <= dc_q * df_q;
      pbf_q <= db_q * df_q;
      pde_q <= dd_q * de_q;
    end
  end

endmodule

// ----- src/bary_fifo.sv -----
// Short queue between the front and back ends.
// No dependencies beyond bary_pkg defaults.
module bary_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = bary_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);
  import bary_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ----- src/bary_back.sv -----
// Back end: divides numerators by the determinant bit by bit, keeps the
// weights, blends attributes and holds the result beat. Uses bary_pkg and the macros.
`include "barycentric_interpolator_macros.svh"
module bary_back #(
  parameter int unsigned CoordBits      = bary_pkg::CoordBitsDef,
  parameter int unsigned WeightFracBits = bary_pkg::WeightFracBitsDef,
  parameter int unsigned AttrBits       = bary_pkg::AttrBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pop_valid_i,
  output logic pop_ready_o,
  input  logic [2+3*(2*CoordBits+3)+3*AttrBits-1:0] pop_data_i,
  bary_out_if.source out_o
);
  import bary_pkg::*;

  localparam int unsigned PW    = 2 * CoordBits + 3;
  localparam int unsigned RW    = PW + 3;
  localparam int unsigned WB    = WeightFracBits + WeightIntBits;
  localparam int unsigned QBits = WB - 1;
  localparam int unsigned CW    = $clog2(QBits);
  localparam int unsigned PRW   = AttrBits + WB;
  localparam int unsigned SW    = PRW + 2;
  localparam int unsigned VW    = SW + AttrFracBits + 1;
  localparam int unsigned TW    = WB + 2;

  localparam logic signed [VW-1:0] AHi = VW'({(AttrBits - 1){1'b1}});
  localparam logic signed [VW-1:0] ALo = -AHi - VW'(1);
  localparam logic signed [TW-1:0] WHi = TW'({(WB - 1){1'b1}});
  localparam logic signed [TW-1:0] WLo = -WHi - TW'(1);
  localparam logic signed [TW-1:0] One = TW'(1) <<< WeightFracBits;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_DIV  = 6'b000010,
    B_WGT  = 6'b000100,
    B_MUL  = 6'b001000,
    B_SUM  = 6'b010000,
    B_FIN  = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;

  logic [1:0]                 in_op;
  logic signed [PW-1:0]       in_det, in_n1, in_n2;
  logic signed [AttrBits-1:0] in_a1, in_a2, in_a3;
  logic [PW-1:0]              ud, un1, un2;
  logic                       pop;

  logic [1:0]                 op_q;
  logic [PW-1:0]              ud_q;
  logic [RW-1:0]              rem1_q, rem2_q, dsh;
  logic [QBits-1:0]           q1_q, q2_q;
  logic                       neg1_q, neg2_q, sat1_q, sat2_q;
  logic [CW-1:0]              cnt_q;
  logic signed [AttrBits-1:0] a1_q, a2_q, a3_q;
  logic signed [WB-1:0]       w_q [3];
  logic signed [PRW-1:0]      p1_q, p2_q, p3_q;
  logic signed [SW-1:0]       sum_q;
  logic                       degen_q;

  logic                       out_valid_q;
  logic signed [WB-1:0]       ow1_q, ow2_q, ow3_q;
  logic signed [AttrBits-1:0] oval_q;
  logic                       odeg_q;

  logic signed [WB-1:0]       w1c, w2c, w3c;
  logic signed [TW-1:0]       t3;
  logic signed [VW-1:0]       vfix, vint, vsel;
  logic [SW-1:0]              smag, sip;
  logic signed [AttrBits-1:0] vsat;
  logic                       out_free;

  assign {in_op, in_det, in_n1, in_n2, in_a1, in_a2, in_a3} = pop_data_i;
  assign pop_ready_o = (state_q == B_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign ud  = in_det[PW-1] ? PW'(-in_det) : PW'(in_det);
  assign un1 = in_n1[PW-1]  ? PW'(-in_n1)  : PW'(in_n1);
  assign un2 = in_n2[PW-1]  ? PW'(-in_n2)  : PW'(in_n2);
  assign dsh = {1'b0, ud_q, 2'b00};

  // quotient to weight with saturation
  assign w1c = sat1_q ? (neg1_q ? WB'(WLo) : WB'(WHi))
                      : (neg1_q ? -WB'({1'b0, q1_q}) : WB'({1'b0, q1_q}));
  assign w2c = sat2_q ? (neg2_q ? WB'(WLo) : WB'(WHi))
                      : (neg2_q ? -WB'({1'b0, q2_q}) : WB'({1'b0, q2_q}));
  assign t3  = One - TW'(w1c) - TW'(w2c);
  assign w3c = (t3 > WHi) ? WB'(WHi) : ((t3 < WLo) ? WB'(WLo) : WB'(t3));

  // blend rounding
  assign vfix = VW'(sum_q >>> WeightFracBits);
  assign smag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign sip  = smag >> (WeightFracBits + AttrFracBits);
  assign vint = (sum_q[SW-1] ? -VW'({1'b0, sip}) : VW'({1'b0, sip})) <<< AttrFracBits;

  always_comb begin
    priority if (op_q == OP_BLEND)     vsel = vfix;
    else if (op_q == OP_BLEND_INT)     vsel = vint;
    else                               vsel = '0;
  end
  assign vsat = (vsel > AHi) ? AttrBits'(AHi)
              : ((vsel < ALo) ? AttrBits'(ALo) : AttrBits'(vsel));

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop) begin
          priority if (in_op == OP_WEIGHTS && in_det != '0) state_d = B_DIV;
          else if (in_op == OP_BLEND || in_op == OP_BLEND_INT) state_d = B_MUL;
          else state_d = B_FIN;
        end
      end
      B_DIV:  if (cnt_q == CW'(QBits - 1)) state_d = B_WGT;
      B_WGT:  state_d = B_FIN;
      B_MUL:  state_d = B_SUM;
      B_SUM:  state_d = B_FIN;
      B_FIN:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      w_q[0]      <= '0;
      w_q[1]      <= '0;
      w_q[2]      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready)             out_valid_q <= 1'b0;
      if (pop && in_op == OP_WEIGHTS && in_det == '0) begin
        w_q[0] <= '0;
        w_q[1] <= '0;
        w_q[2] <= '0;
      end else if (state_q == B_WGT) begin
        w_q[0] <= w1c;
        w_q[1] <= w2c;
        w_q[2] <= w3c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q    <= in_op;
      degen_q <= (in_op == OP_WEIGHTS) && (in_det == '0);
      a1_q    <= in_a1;
      a2_q    <= in_a2;
      a3_q    <= in_a3;
      ud_q    <= ud;
      rem1_q  <= RW'(un1);
      rem2_q  <= RW'(un2);
      neg1_q  <= in_n1[PW-1] ^ in_det[PW-1];
      neg2_q  <= in_n2[PW-1] ^ in_det[PW-1];
      sat1_q  <= {3'b000, un1} >= {ud, 3'b000};
      sat2_q  <= {3'b000, un2} >= {ud, 3'b000};
      q1_q    <= '0;
      q2_q    <= '0;
      cnt_q   <= '0;
    end
    if (state_q == B_DIV) begin
      cnt_q <= cnt_q + 1'b1;
      if (rem1_q >= dsh) begin
        rem1_q <= (rem1_q - dsh) << 1;
        q1_q   <= {q1_q[QBits-2:0], 1'b1};
      end else begin
        rem1_q <= rem1_q << 1;
        q1_q   <= {q1_q[QBits-2:0], 1'b0};
      end
      if (rem2_q >= dsh) begin
        rem2_q <= (rem2_q - dsh) << 1;
        q2_q   <= {q2_q[QBits-2:0], 1'b1};
      end else begin
        rem2_q <= rem2_q << 1;
        q2_q   <= {q2_q[QBits-2:0], 1'b0};
      end
    end
    if (state_q == B_MUL) begin
      p1_q <= a1_q * w_q[0];
      p2_q <= a2_q * w_q[1];
      p3_q <= a3_q * w_q[2];
    end
    if (state_q == B_SUM) begin
      sum_q <= SW'(p1_q) + SW'(p2_q) + SW'(p3_q);
    end
    if (state_q == B_FIN && out_free) begin
      ow1_q  <= w_q[0];
      ow2_q  <= w_q[1];
      ow3_q  <= w_q[2];
      oval_q <= vsat;
      odeg_q <= degen_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.weight1    = ow1_q;
  assign out_o.weight2    = ow2_q;
  assign out_o.weight3    = ow3_q;
  assign out_o.value      = oval_q;
  assign out_o.degenerate = odeg_q;

  `BARY_ASSERT(a_degen_zero, out_valid_q && odeg_q |-> (ow1_q == '0 && ow2_q == '0 && ow3_q == '0), "degenerate beat with nonzero weights")
  `BARY_ASSERT(a_div_count, state_q == B_DIV |-> cnt_q <= CW'(QBits - 1), "divider step count overrun")
  `BARY_ASSERT_ALWAYS(a_load_from_fin, $rose(out_valid_q) |-> $past(state_q == B_FIN), "result loaded outside finish state")

endmodule

// ----- src/barycentric_interpolator.sv -----
// Barycentric interpolator top level: front end, queue and back end.
// Depends on bary_pkg, bary_if, bary_front, bary_fifo and bary_back.
//
// Usage: one input channel (in_i) carries an opcode, three vertex positions,
// a pixel position and three attribute values; one output channel (out_o)
// returns one beat per input beat: the stored weights, the blended value and
// the degenerate flag. Opcode 0 recomputes and stores the weights, opcodes
// 1 and 2 blend an attribute with the stored weights.
// Steps: the front end forms differences, then products, then pushes each
// beat, waiting for room in the queue; the back end runs a weight beat through
// the bit-serial divider, which produces one quotient bit per cycle for both
// weights, then the weight and finish steps; a degenerate or unused-opcode beat
// goes straight to finish, and a blend beat runs multiply, sum and finish. The
// back end takes its next beat only once it is through with the last. A
// two-entry queue lets the front end keep taking beats while the back end works.
// Reset clears the control state and the stored weights to zero; the
// block takes a beat at the first clock edge after reset is released. If the
// receiver stalls, the result beat holds on out_o and the back end waits in
// its finish step; the queue and front end then fill and in_i.ready drops.
module barycentric_interpolator #(
  parameter int unsigned COORD_BITS       = bary_pkg::CoordBitsDef,
  parameter int unsigned WEIGHT_FRAC_BITS = bary_pkg::WeightFracBitsDef,
  parameter int unsigned ATTR_BITS        = bary_pkg::AttrBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  bary_in_if.sink    in_i,
  bary_out_if.source out_o
);
  import bary_pkg::*;

  localparam int unsigned EW = 2 + 3 * (2 * COORD_BITS + 3) + 3 * ATTR_BITS;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0] push_data, pop_data;

  bary_front #(
    .CoordBits (COORD_BITS),
    .AttrBits  (ATTR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  bary_fifo #(
    .Width (EW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  bary_back #(
    .CoordBits      (COORD_BITS),
    .WeightFracBits (WEIGHT_FRAC_BITS),
    .AttrBits       (ATTR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

// ----- dv/barycentric_interpolator_tb.sv -----
// Testbench for the barycentric interpolator: directed and random beats on the
// input channel, an in-bench weight and blend predictor, and a field-by-field
// scoreboard on the output channel. Depends on bary_pkg, bary_if and the RTL.
`timescale 1ns / 100ps

module barycentric_interpolator_tb;
  import bary_pkg::*;

  localparam int unsigned WFRAC = 16;
  localparam int unsigned WBITS = 20;
  localparam int unsigned ABITS = 24;
  localparam longint LIMIT_CYCLES = 600000;

  typedef struct packed {
    opcode_e            op;
    logic signed [15:0] x1, y1, x2, y2, x3, y3, px, py;
    logic signed [23:0] a1, a2, a3;
  } tri_beat_t;

  typedef struct packed {
    logic signed [19:0] w1, w2, w3;
    logic signed [23:0] val;
    logic               degen;
  } interp_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bary_in_if  in_ch ();
  bary_out_if out_ch ();

  barycentric_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  tri_beat_t   pending_beats[$];
  interp_res_t expected_results[$];
  longint      weight_store[3] = '{0, 0, 0};
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_start = 1'b0;
  bit          hold_off = 1'b0;
  int          mismatches = 0;
  longint      cycle_count = 0;
  bit          stim_done = 1'b0;

  function automatic longint clamp(longint v, int unsigned bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint weight_quot(longint n, longint d);
    bit     neg;
    longint un, ud, q, r, lim;
    int     i;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    lim = longint'(1) << (WBITS - 1);
    q = un / ud;
    r = un % ud;
    for (i = 0; i < WFRAC && q < lim; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= ud) begin
        r -= ud;
        q |= 1;
      end
    end
    if (i < WFRAC || q >= lim) return neg ? -lim : lim - 1;
    return neg ? -q : q;
  endfunction

  function automatic interp_res_t predict_interp(tri_beat_t b);
    interp_res_t res;
    longint det, n1, n2, s, m, v;
    v = 0;
    res.degen = 1'b0;
    if (b.op == OP_WEIGHTS) begin
      det = (longint'(b.y2) - b.y3) * (longint'(b.x1) - b.x3)
          + (longint'(b.x3) - b.x2) * (longint'(b.y1) - b.y3);
      if (det == 0) begin
        weight_store = '{0, 0, 0};
        res.degen = 1'b1;
      end else begin
        n1 = (longint'(b.y2) - b.y3) * (longint'(b.px) - b.x3)
           + (longint'(b.x3) - b.x2) * (longint'(b.py) - b.y3);
        n2 = (longint'(b.y3) - b.y1) * (longint'(b.px) - b.x3)
           + (longint'(b.x1) - b.x3) * (longint'(b.py) - b.y3);
        weight_store[0] = weight_quot(n1, det);
        weight_store[1] = weight_quot(n2, det);
        weight_store[2] = clamp((longint'(1) << WFRAC) - weight_store[0]
                                - weight_store[1], WBITS);
      end
    end else if (b.op == OP_BLEND || b.op == OP_BLEND_INT) begin
      s = longint'(b.a1) * weight_store[0] + longint'(b.a2) * weight_store[1]
        + longint'(b.a3) * weight_store[2];
      m = (s < 0) ? -s : s;
      if (b.op == OP_BLEND) begin
        v = s >>> WFRAC;
      end else begin
        v = m >> (WFRAC + AttrFracBits);
        if (s < 0) v = -v;
        v = v * 256;
      end
      v = clamp(v, ABITS);
    end
    res.w1 = weight_store[0][19:0];
    res.w2 = weight_store[1][19:0];
    res.w3 = weight_store[2][19:0];
    res.val = v[23:0];
    return res;
  endfunction

  function automatic tri_beat_t rand_beat(opcode_e op, bit wide);
    tri_beat_t b;
    b.op = op;
    if (wide) begin
      {b.x1, b.y1, b.x2, b.y2} = {$urandom, $urandom};
      {b.x3, b.y3, b.px, b.py} = {$urandom, $urandom};
    end else begin
      b.x1 = 16'($urandom_range(0, 4095) - 2048);
      b.y1 = 16'($urandom_range(0, 4095) - 2048);
      b.x2 = 16'($urandom_range(0, 4095) - 2048);
      b.y2 = 16'($urandom_range(0, 4095) - 2048);
      b.x3 = 16'($urandom_range(0, 4095) - 2048);
      b.y3 = 16'($urandom_range(0, 4095) - 2048);
      b.px = 16'($urandom_range(0, 4095) - 2048);
      b.py = 16'($urandom_range(0, 4095) - 2048);
    end
    b.a1 = 24'($urandom);
    b.a2 = 24'($urandom);
    b.a3 = 24'($urandom);
    return b;
  endfunction

  // driver: drop the accepted beat, then offer the head of the queue
  always @(posedge clk_i or negedge rst_ni) begin
    tri_beat_t nb;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= OP_WEIGHTS;
      {in_ch.x1, in_ch.y1, in_ch.x2, in_ch.y2} <= '0;
      {in_ch.x3, in_ch.y3, in_ch.px, in_ch.py} <= '0;
      {in_ch.attr1, in_ch.attr2, in_ch.attr3} <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_interp(pending_beats.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nb = pending_beats[0];
          in_ch.valid <= 1'b1;
          in_ch.opcode <= nb.op;
          {in_ch.x1, in_ch.y1, in_ch.x2, in_ch.y2} <= {nb.x1, nb.y1, nb.x2, nb.y2};
          {in_ch.x3, in_ch.y3, in_ch.px, in_ch.py} <= {nb.x3, nb.y3, nb.px, nb.py};
          {in_ch.attr1, in_ch.attr2, in_ch.attr3} <= {nb.a1, nb.a2, nb.a3};
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off, counted in cycles
  initial begin
    wait (hold_start);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    interp_res_t exp_r;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat w=%h/%h/%h v=%h d=%b", $time,
                   out_ch.weight1, out_ch.weight2, out_ch.weight3, out_ch.value,
                   out_ch.degenerate);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.weight1 !== exp_r.w1 || out_ch.weight2 !== exp_r.w2 ||
              out_ch.weight3 !== exp_r.w3 || out_ch.value !== exp_r.val ||
              out_ch.degenerate !== exp_r.degen) begin
            $display("%0t: expected w=%h/%h/%h v=%h d=%b, got w=%h/%h/%h v=%h d=%b",
                     $time, exp_r.w1, exp_r.w2, exp_r.w3, exp_r.val, exp_r.degen,
                     out_ch.weight1, out_ch.weight2, out_ch.weight3, out_ch.value,
                     out_ch.degenerate);
            mismatches++;
          end
        end
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic queue_random(int count);
    int      k;
    opcode_e op;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: op = OP_WEIGHTS;
        3, 4, 5: op = OP_BLEND;
        6, 7, 8: op = OP_BLEND_INT;
        default: op = OP_RSVD;
      endcase
      pending_beats.push_back(rand_beat(op, $urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    tri_beat_t b;
    int        k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // blend on reset weights, reserved opcode
    pending_beats.push_back(rand_beat(OP_BLEND, 1'b0));
    pending_beats.push_back(rand_beat(OP_RSVD, 1'b1));
    // right triangle with legs of 16, pixel inside
    b = '{OP_WEIGHTS, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16,
          16'sd4, 16'sd4, 24'sd256, 24'sd512, 24'sd768};
    pending_beats.push_back(b);
    b.op = OP_BLEND;
    pending_beats.push_back(b);
    b.op = OP_BLEND_INT;
    b.a1 = -24'sd300;
    pending_beats.push_back(b);
    b.op = OP_BLEND;
    b = '{OP_BLEND, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 24'h7fffff, 24'h800000, 24'h7fffff};
    pending_beats.push_back(b);
    // degenerate: collinear points
    b = '{OP_WEIGHTS, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd32, 16'sd32,
          16'sd5, 16'sd9, 24'sd0, 24'sd0, 24'sd0};
    pending_beats.push_back(b);
    b.op = OP_BLEND;
    pending_beats.push_back(b);
    // tiny triangle, pixel far away: weights saturate
    b = '{OP_WEIGHTS, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1,
          16'h7fff, 16'h8000, 24'h7fffff, 24'h800000, 24'h7fffff};
    pending_beats.push_back(b);
    b.op = OP_BLEND;
    pending_beats.push_back(b);
    b.op = OP_BLEND_INT;
    pending_beats.push_back(b);
    // extreme coordinates
    b = '{OP_WEIGHTS, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
          16'h7fff, 16'h7fff, 24'h800000, 24'h800000, 24'h800000};
    pending_beats.push_back(b);
    b.op = OP_BLEND;
    pending_beats.push_back(b);
    b.op = OP_BLEND_INT;
    pending_beats.push_back(b);
    b = '{OP_WEIGHTS, 16'hffff, 16'h7fff, 16'h8000, 16'hffff, 16'h0, 16'h8000,
          16'h8000, 16'h8000, 24'hffffff, 24'h000001, 24'h7fffff};
    pending_beats.push_back(b);
    b.op = OP_BLEND_INT;
    pending_beats.push_back(b);
    wait_drained();

    send_idle_pct = 9;
    recv_idle_pct = 76;
    queue_random(180);
    wait_drained();

    send_idle_pct = 76;
    recv_idle_pct = 9;
    queue_random(180);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(40);
    hold_start <= 1'b1;
    for (k = 0; k < 400; k++) @(posedge clk_i);
    queue_random(140);
    wait_drained();
    stim_done = 1'b1;
  end

  always @(posedge clk_i) begin
    if (stim_done) begin
      if (mismatches == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
      $finish;
    end else if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
